// ===== sv/aul_pkg.sv =====
// Shared item types and codes for the array union/intersection block.
package aul_pkg;

   // input item modes
   localparam logic [1:0] MODE_LOAD_FIRST  = 2'd0;
   localparam logic [1:0] MODE_LOAD_SECOND = 2'd1;
   localparam logic [1:0] MODE_CLEAR       = 2'd2;
   localparam logic [1:0] MODE_FETCH       = 2'd3;

   // result item kinds
   localparam logic [1:0] KIND_UNION = 2'd0;
   localparam logic [1:0] KIND_INTER = 2'd1;
   localparam logic [1:0] KIND_EMPTY = 2'd2;
   localparam logic [1:0] KIND_NONE  = 2'd3;

   typedef struct packed {
      logic [1:0]         mode;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic [1:0]         kind;
      logic signed [31:0] value_res;
      logic               last;
   } rsp_type;

   // sequencer status toward the output stage
   typedef struct packed {
      logic busy;
      logic res_valid;
   } seq_stat_type;

endpackage

// ===== sv/aul_store.sv =====
// Element store: one write port, one read port with registered read data.
module aul_store #(
   parameter int DEPTH = 64
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [31:0]                                 wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [31:0]                                 rd_data
);

   logic [31:0] mem [DEPTH];
   logic [31:0] rd_data_ff;

   // write on enable, read every cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/aul_seq.sv =====
// Sequencer: counts, answer cursor and the shared element comparator.
module aul_seq #(
   parameter int MAX_LEN = 64
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          req_fire,
   input  aul_pkg::req_type                              req_in,
   input  logic                                          out_free,
   output aul_pkg::seq_stat_type                         stat,
   output aul_pkg::rsp_type                              res,
   output logic                                          wr_first,
   output logic                                          wr_second,
   output logic [((MAX_LEN > 1) ? $clog2(MAX_LEN) : 1)-1:0] wr_addr,
   output logic [31:0]                                   wr_data,
   output logic [((MAX_LEN > 1) ? $clog2(MAX_LEN) : 1)-1:0] rd_addr_first,
   output logic [((MAX_LEN > 1) ? $clog2(MAX_LEN) : 1)-1:0] rd_addr_second,
   input  logic [31:0]                                   rd_data_first,
   input  logic [31:0]                                   rd_data_second
);

   localparam int CW = $clog2(MAX_LEN + 1);
   localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

   typedef enum logic [3:0] {
      S_IDLE, S_COPY, S_COPYD, S_XRD, S_XGET, S_SRD, S_SCMP, S_IRD, S_ICMP, S_OUT
   } state_type;

   typedef enum logic [1:0] {
      PH_COPY, PH_EXTRA, PH_INTER, PH_DONE
   } phase_type;

   state_type        state_ff, state_in;
   phase_type        phase_ff, phase_in;
   logic [CW-1:0]    outer_ff, outer_in;
   logic [CW-1:0]    inner_ff, inner_in;
   logic             any_ff, any_in;
   logic             peek_ff, peek_in;
   logic [CW-1:0]    sv_outer_ff, sv_outer_in;
   logic [CW-1:0]    sv_inner_ff, sv_inner_in;
   logic [CW-1:0]    cnt_first_ff, cnt_first_in;
   logic [CW-1:0]    cnt_second_ff, cnt_second_in;
   logic [31:0]      x_ff, x_in;
   aul_pkg::rsp_type res_ff, res_in;

   logic             restart;
   logic             first_long;
   logic [CW-1:0]    nl, ns;
   logic [31:0]      lng_q, sht_q, cmp_a;
   logic             eq;
   logic [AW-1:0]    la, sa;

   // long/short roles: first array is long on a tie
   assign first_long = cnt_first_ff >= cnt_second_ff;
   assign nl         = first_long ? cnt_first_ff : cnt_second_ff;
   assign ns         = first_long ? cnt_second_ff : cnt_first_ff;
   assign lng_q      = first_long ? rd_data_first : rd_data_second;
   assign sht_q      = first_long ? rd_data_second : rd_data_first;

   // read addresses: long side at the outer index, short side at outer or inner
   assign la             = outer_ff[AW-1:0];
   assign sa             = (state_ff == S_COPY) ? outer_ff[AW-1:0] : inner_ff[AW-1:0];
   assign rd_addr_first  = first_long ? la : sa;
   assign rd_addr_second = first_long ? sa : la;

   // the one shared comparator
   assign cmp_a = (state_ff == S_SCMP) ? x_ff : lng_q;
   assign eq    = (cmp_a == sht_q);

   // load writes
   assign wr_data = req_in.value;
   assign wr_addr = (req_in.mode == aul_pkg::MODE_LOAD_FIRST) ?
                    cnt_first_ff[AW-1:0] : cnt_second_ff[AW-1:0];

   // next-state logic
   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      outer_in      = outer_ff;
      inner_in      = inner_ff;
      any_in        = any_ff;
      peek_in       = peek_ff;
      sv_outer_in   = sv_outer_ff;
      sv_inner_in   = sv_inner_ff;
      cnt_first_in  = cnt_first_ff;
      cnt_second_in = cnt_second_ff;
      x_in          = x_ff;
      res_in        = res_ff;
      restart       = 1'b0;
      wr_first      = 1'b0;
      wr_second     = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               case (req_in.mode)
                  aul_pkg::MODE_LOAD_FIRST: begin
                     if (cnt_first_ff < CW'(MAX_LEN)) begin
                        wr_first     = 1'b1;
                        cnt_first_in = cnt_first_ff + CW'(1);
                     end
                     restart = 1'b1;
                  end
                  aul_pkg::MODE_LOAD_SECOND: begin
                     if (cnt_second_ff < CW'(MAX_LEN)) begin
                        wr_second     = 1'b1;
                        cnt_second_in = cnt_second_ff + CW'(1);
                     end
                     restart = 1'b1;
                  end
                  aul_pkg::MODE_CLEAR: begin
                     cnt_first_in  = '0;
                     cnt_second_in = '0;
                     restart       = 1'b1;
                  end
                  aul_pkg::MODE_FETCH: begin
                     case (phase_ff)
                        PH_COPY:  state_in = S_COPY;
                        PH_EXTRA: state_in = S_XRD;
                        PH_INTER: state_in = S_IRD;
                        default: begin
                           res_in.kind      = aul_pkg::KIND_NONE;
                           res_in.value_res = '0;
                           res_in.last      = 1'b0;
                           state_in         = S_OUT;
                        end
                     endcase
                  end
                  default: ;
               endcase
            end
         end

         // union: every short element in order
         S_COPY: begin
            if (outer_ff < ns) begin
               state_in = S_COPYD;
            end else begin
               phase_in = PH_EXTRA;
               outer_in = '0;
               state_in = S_XRD;
            end
         end
         S_COPYD: begin
            res_in.kind      = aul_pkg::KIND_UNION;
            res_in.value_res = $signed(sht_q);
            res_in.last      = 1'b0;
            outer_in         = outer_ff + CW'(1);
            state_in         = S_OUT;
         end

         // union: long elements absent from the short array
         S_XRD: begin
            if (outer_ff < nl) begin
               outer_in = outer_ff + CW'(1);
               inner_in = '0;
               state_in = S_XGET;
            end else begin
               phase_in = PH_INTER;
               outer_in = '0;
               inner_in = '0;
               state_in = S_IRD;
            end
         end
         S_XGET: begin
            x_in     = lng_q;
            state_in = S_SRD;
         end
         S_SRD: begin
            if (inner_ff < ns) begin
               inner_in = inner_ff + CW'(1);
               state_in = S_SCMP;
            end else begin
               res_in.kind      = aul_pkg::KIND_UNION;
               res_in.value_res = $signed(x_ff);
               res_in.last      = 1'b0;
               state_in         = S_OUT;
            end
         end
         S_SCMP: begin
            state_in = eq ? S_XRD : S_SRD;
         end

         // intersection scan; peek mode looks for a further match only
         S_IRD: begin
            if (outer_ff < nl) begin
               if (inner_ff < ns) begin
                  inner_in = inner_ff + CW'(1);
                  state_in = S_ICMP;
               end else begin
                  inner_in = '0;
                  outer_in = outer_ff + CW'(1);
               end
            end else begin
               phase_in = PH_DONE;
               state_in = S_OUT;
               if (peek_ff) begin
                  peek_in     = 1'b0;
                  res_in.last = 1'b1;
               end else if (!any_ff) begin
                  res_in.kind      = aul_pkg::KIND_EMPTY;
                  res_in.value_res = '0;
                  res_in.last      = 1'b1;
               end else begin
                  res_in.kind      = aul_pkg::KIND_NONE;
                  res_in.value_res = '0;
                  res_in.last      = 1'b0;
               end
            end
         end
         S_ICMP: begin
            state_in = S_IRD;
            if (eq) begin
               if (!peek_ff) begin
                  res_in.kind      = aul_pkg::KIND_INTER;
                  res_in.value_res = $signed(lng_q);
                  res_in.last      = 1'b0;
                  any_in           = 1'b1;
                  peek_in          = 1'b1;
                  sv_outer_in      = outer_ff;
                  sv_inner_in      = inner_ff;
               end else begin
                  // another match exists: rewind to just after the emitted one
                  outer_in    = sv_outer_ff;
                  inner_in    = sv_inner_ff;
                  peek_in     = 1'b0;
                  res_in.last = 1'b0;
                  state_in    = S_OUT;
               end
            end
         end

         S_OUT: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase

      // any load or clear starts the answer over
      if (restart) begin
         phase_in = PH_COPY;
         outer_in = '0;
         inner_in = '0;
         any_in   = 1'b0;
         peek_in  = 1'b0;
      end
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      x_ff        <= x_in;
      sv_outer_ff <= sv_outer_in;
      sv_inner_ff <= sv_inner_in;
      res_ff      <= res_in;
      if (reset) begin
         state_ff      <= S_IDLE;
         phase_ff      <= PH_COPY;
         outer_ff      <= '0;
         inner_ff      <= '0;
         any_ff        <= 1'b0;
         peek_ff       <= 1'b0;
         cnt_first_ff  <= '0;
         cnt_second_ff <= '0;
      end else begin
         state_ff      <= state_in;
         phase_ff      <= phase_in;
         outer_ff      <= outer_in;
         inner_ff      <= inner_in;
         any_ff        <= any_in;
         peek_ff       <= peek_in;
         cnt_first_ff  <= cnt_first_in;
         cnt_second_ff <= cnt_second_in;
      end
   end

   assign res            = res_ff;
   assign stat.busy      = (state_ff != S_IDLE);
   assign stat.res_valid = (state_ff == S_OUT);

endmodule

// ===== sv/array_union_intersection.sv =====
// Load and clear items are taken while the sequencer is idle. A fetch steps through the arrays
// comparing one element pair at a time; the worst fetch is a full scan of both stores. The pace
// is set by the single read port of each store feeding one comparator.
// One item at a time: req_stall is high while a fetch is being worked on.
// Reset clears counts and restarts the answer; store contents are not cleared.
module array_union_intersection #(
   parameter int MAX_LEN = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  aul_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output aul_pkg::rsp_type rsp_data
);

   localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

   aul_pkg::seq_stat_type stat;
   aul_pkg::rsp_type      res;
   aul_pkg::rsp_type      rsp_data_ff;
   logic                  rsp_valid_ff;
   logic                  req_fire;
   logic                  out_free;
   logic                  wr_first, wr_second;
   logic [AW-1:0]         wr_addr, rd_addr_first, rd_addr_second;
   logic [31:0]           wr_data, rd_data_first, rd_data_second;

   assign req_stall = stat.busy;
   assign req_fire  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   aul_seq #(.MAX_LEN(MAX_LEN)) u_seq (
      .clock          (clock),
      .reset          (reset),
      .req_fire       (req_fire),
      .req_in         (req_data),
      .out_free       (out_free),
      .stat           (stat),
      .res            (res),
      .wr_first       (wr_first),
      .wr_second      (wr_second),
      .wr_addr        (wr_addr),
      .wr_data        (wr_data),
      .rd_addr_first  (rd_addr_first),
      .rd_addr_second (rd_addr_second),
      .rd_data_first  (rd_data_first),
      .rd_data_second (rd_data_second)
   );

   aul_store #(.DEPTH(MAX_LEN)) u_first (
      .clock   (clock),
      .wr_en   (wr_first),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr_first),
      .rd_data (rd_data_first)
   );

   aul_store #(.DEPTH(MAX_LEN)) u_second (
      .clock   (clock),
      .wr_en   (wr_second),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr_second),
      .rd_data (rd_data_second)
   );

   // output register between the sequencer and the result channel
   always_ff @(posedge clock) begin
      if (stat.res_valid && out_free) begin
         rsp_data_ff <= res;
      end
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (stat.res_valid && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== sv/aul_check.sv =====
// Port-level assertions for the array union/intersection block, with bind.
module aul_check (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input aul_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input aul_pkg::rsp_type rsp_data
);

   // the block is ready right after reset
   a_reset_ready: assert property (@(posedge clock) reset |=> !req_stall)
      else $error("not ready after reset");

   // a fetch item always keeps the sequencer busy in the cycle after it is accepted
   a_fetch_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_data.mode == aul_pkg::MODE_FETCH) |=> req_stall)
      else $error("fetch did not occupy the block");

   // load and clear items make no result
   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid && req_valid && !req_stall && req_data.mode != aul_pkg::MODE_FETCH)
      |=> !rsp_valid)
      else $error("result without a fetch");

   // a stalled result item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled result changed");

endmodule

bind array_union_intersection aul_check u_check (.*);
